@@ src/ray_obb_slab_intersection_defines.svh @@
// ----------------------------------------------------------------------------
// ray_obb_slab_intersection_defines.svh
// Assertion macros shared by the ray / oriented box slab test.
// ----------------------------------------------------------------------------
`ifndef RAY_OBB_SLAB_INTERSECTION_DEFINES_SVH
`define RAY_OBB_SLAB_INTERSECTION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ROSI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ROSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/rosi_pkg.sv @@
// ----------------------------------------------------------------------------
// rosi_pkg
// Widths, register indexes and shared types of the ray / oriented box test.
// ----------------------------------------------------------------------------
package rosi_pkg;

	localparam int DIR_FRAC   = 14;
	localparam int NUM_COMP   = 3;
	localparam int NUM_SLABS  = 3;
	localparam int COORD_W    = 32;
	localparam int DIR_W      = 16;
	localparam int HALF_W     = 31;
	localparam int CFG_W      = 48;
	localparam int THR_W      = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PE_W       = DIR_W + DIFF_W;
	localparam int PF_W       = 2 * DIR_W;
	localparam int E_W        = PE_W + 2;
	localparam int F_W        = PF_W + 2;
	localparam int NUM_W      = E_W + 2;
	localparam int DEN_W      = 32;
	localparam int QUO_W      = 31;
	localparam int LOW_W      = QUO_W - DIR_FRAC;
	localparam int DIV_STAGES = QUO_W;
	localparam int LANE_LAT   = 3 + DIV_STAGES;
	localparam int PIPE_LAT   = 1 + LANE_LAT + 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_ONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_TWO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_THREE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd3;

	localparam logic [CFG_W-1:0] AXIS_ONE_RST   = 48'h0000_0000_4000;
	localparam logic [CFG_W-1:0] AXIS_TWO_RST   = 48'h0000_4000_0000;
	localparam logic [CFG_W-1:0] AXIS_THREE_RST = 48'h4000_0000_0000;

	localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

	// divider entry: initial remainder, divisor, low dividend bits, overflow and sign
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [LOW_W-1:0] low;
		logic             ovf;
		logic             neg;
	} rosi_div_in_t;

	// divider result: quotient magnitude, overflow and sign
	typedef struct packed {
		logic [QUO_W-1:0] quo;
		logic             ovf;
		logic             neg;
	} rosi_quo_t;

	// what one slab lane hands to the merge
	typedef struct packed {
		rosi_quo_t t_a;
		rosi_quo_t t_b;
		logic      par;
		logic      outside;
	} rosi_slab_t;

endpackage

@@ src/rosi_ifs.sv @@
// ----------------------------------------------------------------------------
// rosi_ifs
// Ray item channel and result item channel, valid / ready handshake.
// ----------------------------------------------------------------------------
interface rosi_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [rosi_pkg::COORD_W-1:0]    origin_x;
	logic signed [rosi_pkg::COORD_W-1:0]    origin_y;
	logic signed [rosi_pkg::COORD_W-1:0]    origin_z;
	logic signed [rosi_pkg::DIR_W-1:0]      dir_x;
	logic signed [rosi_pkg::DIR_W-1:0]      dir_y;
	logic signed [rosi_pkg::DIR_W-1:0]      dir_z;
	logic signed [rosi_pkg::COORD_W-1:0]    center_x;
	logic signed [rosi_pkg::COORD_W-1:0]    center_y;
	logic signed [rosi_pkg::COORD_W-1:0]    center_z;
	logic        [rosi_pkg::HALF_W-1:0]     half_one;
	logic        [rosi_pkg::HALF_W-1:0]     half_two;
	logic        [rosi_pkg::HALF_W-1:0]     half_three;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		center_x, center_y, center_z, half_one, half_two, half_three, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		center_x, center_y, center_z, half_one, half_two, half_three, output ready);
endinterface

interface rosi_out_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   hit;
	logic signed [rosi_pkg::COORD_W-1:0]    hit_distance;

	modport source (output valid, hit, hit_distance, input ready);
	modport sink (input valid, hit, hit_distance, output ready);
endinterface

@@ src/rosi_div.sv @@
// ----------------------------------------------------------------------------
// rosi_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rosi_div (
	input  logic                   clk,
	input  logic                   en,
	input  rosi_pkg::rosi_div_in_t din,
	output rosi_pkg::rosi_quo_t    dout
);

	localparam int DEN_W  = rosi_pkg::DEN_W;
	localparam int QUO_W  = rosi_pkg::QUO_W;
	localparam int LOW_W  = rosi_pkg::LOW_W;
	localparam int STAGES = rosi_pkg::DIV_STAGES;

	logic [DEN_W-1:0] rem_q [STAGES];
	logic [DEN_W-1:0] den_q [STAGES];
	logic [LOW_W-1:0] low_q [STAGES];
	logic [QUO_W-1:0] quo_q [STAGES];
	logic             ovf_q [STAGES];
	logic             neg_q [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stg
		localparam int J = QUO_W - 1 - i;
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [LOW_W-1:0] low_in;
		logic [QUO_W-1:0] quo_in;
		logic             ovf_in;
		logic             neg_in;
		logic             bit_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in = din.rem;
			assign den_in = din.den;
			assign low_in = din.low;
			assign quo_in = '0;
			assign ovf_in = din.ovf;
			assign neg_in = din.neg;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign den_in = den_q[i-1];
			assign low_in = low_q[i-1];
			assign quo_in = quo_q[i-1];
			assign ovf_in = ovf_q[i-1];
			assign neg_in = neg_q[i-1];
		end

		// dividend bit J; the scaled dividend has zeros below DIR_FRAC
		if (J >= rosi_pkg::DIR_FRAC) begin : g_bit
			assign bit_in = low_in[J-rosi_pkg::DIR_FRAC];
		end else begin : g_zero
			assign bit_in = 1'b0;
		end

		assign trial = {rem_in, bit_in};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				den_q[i] <= den_in;
				low_q[i] <= low_in;
				quo_q[i] <= {quo_in[QUO_W-2:0], ge};
				ovf_q[i] <= ovf_in;
				neg_q[i] <= neg_in;
			end
		end
	end

	assign dout.quo = quo_q[STAGES-1];
	assign dout.ovf = ovf_q[STAGES-1];
	assign dout.neg = neg_q[STAGES-1];

endmodule

@@ src/rosi_lane.sv @@
// ----------------------------------------------------------------------------
// rosi_lane
// One slab: dot products, numerators, parallel and outside tests and two divisions.
// ----------------------------------------------------------------------------
module rosi_lane (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic        [rosi_pkg::CFG_W-1:0]    axis,
	input  logic        [rosi_pkg::THR_W-1:0]    thr,
	input  logic signed [rosi_pkg::DIFF_W-1:0]   diff [rosi_pkg::NUM_COMP],
	input  logic signed [rosi_pkg::DIR_W-1:0]    dir  [rosi_pkg::NUM_COMP],
	input  logic        [rosi_pkg::HALF_W-1:0]   half,
	output rosi_pkg::rosi_slab_t                 slab
);

	localparam int NC    = rosi_pkg::NUM_COMP;
	localparam int DF    = rosi_pkg::DIR_FRAC;
	localparam int DW    = rosi_pkg::DIR_W;
	localparam int PE_W  = rosi_pkg::PE_W;
	localparam int PF_W  = rosi_pkg::PF_W;
	localparam int E_W   = rosi_pkg::E_W;
	localparam int F_W   = rosi_pkg::F_W;
	localparam int NUM_W = rosi_pkg::NUM_W;
	localparam int DEN_W = rosi_pkg::DEN_W;
	localparam int LOW_W = rosi_pkg::LOW_W;
	localparam int H_W   = rosi_pkg::HALF_W + DF;
	localparam int STG   = rosi_pkg::DIV_STAGES;

	logic signed [DW-1:0]   a_c [NC];
	logic signed [PE_W-1:0] pe_s2 [NC];
	logic signed [PF_W-1:0] pf_s2 [NC];
	logic [rosi_pkg::HALF_W-1:0] half_s2, half_s3;
	logic signed [E_W-1:0]  e_s3;
	logic signed [F_W-1:0]  f_s3;

	logic [H_W-1:0]          h_c;
	logic signed [NUM_W-1:0] num_a, num_b;
	logic [NUM_W-2:0]        un_a, un_b;
	logic [E_W-2:0]          abs_e;
	logic [DEN_W-1:0]        ud;
	logic                    par_c, out_c;
	rosi_pkg::rosi_div_in_t  dva_c, dvb_c, dva_s4, dvb_s4;
	logic [1:0]              flg_s4;
	logic [1:0]              flg_q [STG];
	rosi_pkg::rosi_quo_t     qa, qb;

	// axis components, x low
	always_comb begin
		for (int k = 0; k < NC; k++) begin
			a_c[k] = axis[k*DW +: DW];
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NC; k++) begin
				pe_s2[k] <= a_c[k] * diff[k];
				pf_s2[k] <= a_c[k] * dir[k];
			end
			half_s2 <= half;
		end
	end

	// dot products e and f
	always_ff @(posedge clk) begin
		if (en) begin
			e_s3    <= E_W'(pe_s2[0]) + E_W'(pe_s2[1]) + E_W'(pe_s2[2]);
			f_s3    <= F_W'(pf_s2[0]) + F_W'(pf_s2[1]) + F_W'(pf_s2[2]);
			half_s3 <= half_s2;
		end
	end

	// numerators, magnitudes, parallel and overflow tests
	always_comb begin
		h_c   = {half_s3, {DF{1'b0}}};
		num_a = NUM_W'(e_s3) + NUM_W'(h_c);
		num_b = NUM_W'(e_s3) - NUM_W'(h_c);
		un_a  = num_a[NUM_W-1] ? (NUM_W-1)'(-num_a) : (NUM_W-1)'(num_a);
		un_b  = num_b[NUM_W-1] ? (NUM_W-1)'(-num_b) : (NUM_W-1)'(num_b);
		abs_e = e_s3[E_W-1] ? (E_W-1)'(-e_s3) : (E_W-1)'(e_s3);
		ud    = f_s3[F_W-1] ? DEN_W'(-f_s3) : DEN_W'(f_s3);
		par_c = (ud <= DEN_W'({thr, {DF{1'b0}}}));
		out_c = (abs_e > (E_W-1)'(h_c));

		dva_c.rem = un_a[LOW_W +: DEN_W];
		dva_c.den = ud;
		dva_c.low = un_a[LOW_W-1:0];
		dva_c.ovf = (un_a >= (NUM_W-1)'({ud, {LOW_W{1'b0}}}));
		dva_c.neg = num_a[NUM_W-1] ^ f_s3[F_W-1];

		dvb_c.rem = un_b[LOW_W +: DEN_W];
		dvb_c.den = ud;
		dvb_c.low = un_b[LOW_W-1:0];
		dvb_c.ovf = (un_b >= (NUM_W-1)'({ud, {LOW_W{1'b0}}}));
		dvb_c.neg = num_b[NUM_W-1] ^ f_s3[F_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dva_s4 <= dva_c;
			dvb_s4 <= dvb_c;
			flg_s4 <= {par_c, out_c};
		end
	end

	rosi_div u_div_a (.clk(clk), .en(en), .din(dva_s4), .dout(qa));
	rosi_div u_div_b (.clk(clk), .en(en), .din(dvb_s4), .dout(qb));

	// slab flags ride alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			flg_q[0] <= flg_s4;
			for (int i = 1; i < STG; i++) begin
				flg_q[i] <= flg_q[i-1];
			end
		end
	end

	assign slab.t_a     = qa;
	assign slab.t_b     = qb;
	assign slab.par     = flg_q[STG-1][1];
	assign slab.outside = flg_q[STG-1][0];

endmodule

@@ src/rosi_merge.sv @@
// ----------------------------------------------------------------------------
// rosi_merge
// Saturates and orders each slab's distances, then narrows the interval.
// ----------------------------------------------------------------------------
module rosi_merge (
	input  logic                                clk,
	input  logic                                en,
	input  rosi_pkg::rosi_slab_t                slab [rosi_pkg::NUM_SLABS],
	output logic                                hit,
	output logic signed [rosi_pkg::COORD_W-1:0] distance
);

	localparam int NS = rosi_pkg::NUM_SLABS;
	localparam int CW = rosi_pkg::COORD_W;

	logic signed [CW-1:0] ta_c [NS], tb_c [NS];
	logic signed [CW-1:0] lo_m1 [NS], hi_m1 [NS];
	logic [NS-1:0]        par_m1, out_m1;
	logic signed [CW-1:0] tmin_c, tmax_c, dist_c;
	logic                 miss_c, hit_c;
	logic                 hit_m2;
	logic signed [CW-1:0] dist_m2;

	// signed, saturated distance from quotient magnitude
	function automatic logic signed [CW-1:0] to_dist(input rosi_pkg::rosi_quo_t x);
		logic signed [CW-1:0] r;
		if (x.neg) begin
			r = x.ovf ? rosi_pkg::Q_MIN : -CW'(x.quo);
		end else begin
			r = x.ovf ? rosi_pkg::Q_MAX : CW'(x.quo);
		end
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			ta_c[i] = to_dist(slab[i].t_a);
			tb_c[i] = to_dist(slab[i].t_b);
		end
	end

	// put each slab's pair in order
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NS; i++) begin
				lo_m1[i]  <= (ta_c[i] > tb_c[i]) ? tb_c[i] : ta_c[i];
				hi_m1[i]  <= (ta_c[i] > tb_c[i]) ? ta_c[i] : tb_c[i];
				par_m1[i] <= slab[i].par;
				out_m1[i] <= slab[i].outside;
			end
		end
	end

	// interval narrowing over the slabs that are not parallel
	always_comb begin
		tmin_c = rosi_pkg::Q_MIN;
		tmax_c = rosi_pkg::Q_MAX;
		miss_c = 1'b0;
		for (int i = 0; i < NS; i++) begin
			if (par_m1[i]) begin
				miss_c = miss_c | out_m1[i];
			end else begin
				if (lo_m1[i] > tmin_c) tmin_c = lo_m1[i];
				if (hi_m1[i] < tmax_c) tmax_c = hi_m1[i];
			end
		end
		hit_c  = !miss_c && (tmin_c <= tmax_c) && !tmax_c[CW-1];
		dist_c = hit_c ? ((tmin_c > 0) ? tmin_c : tmax_c) : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_m2  <= hit_c;
			dist_m2 <= dist_c;
		end
	end

	assign hit      = hit_m2;
	assign distance = dist_m2;

endmodule

@@ src/ray_obb_slab_intersection.sv @@
// ----------------------------------------------------------------------------
// ray_obb_slab_intersection
// Ray versus oriented box slab test, one item per cycle unless res_out stalls.
// ----------------------------------------------------------------------------
// Use: ray_in carries a ray (origin, unit direction) and a box (center, three
// half sizes); res_out returns hit and hit_distance for each item, in order.
// The three box axes and the parallel threshold are written by the user via
// cfg_we / cfg_idx / cfg_data while no item is in flight (not enforced).
// Pipeline: one input stage, three stages of dot products and numerators, 31
// stages of the bit-per-stage dividers, and two merge stages.
// Throughput: one item per cycle while res_out is not stalled, six dividers
// (two per slab lane) running in parallel with a new item entering every stage.
// Reset: arst_n clears all in-flight items and restores the axes to unit x,
// y, z and the threshold to zero.
// Stall: when a result waits and res_out.ready is low the whole pipeline
// holds; ray_in.ready is high whenever the last stage is empty or is taken.
// ----------------------------------------------------------------------------
`include "ray_obb_slab_intersection_defines.svh"

module ray_obb_slab_intersection (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rosi_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rosi_pkg::CFG_W-1:0]         cfg_data,
	rosi_in_if.sink                            ray_in,
	rosi_out_if.source                         res_out
);

	localparam int NS  = rosi_pkg::NUM_SLABS;
	localparam int NC  = rosi_pkg::NUM_COMP;
	localparam int LAT = rosi_pkg::PIPE_LAT;
	localparam int DW  = rosi_pkg::DIFF_W;

	logic [rosi_pkg::CFG_W-1:0]  axis_q [NS];
	logic [rosi_pkg::THR_W-1:0]  thr_q;
	logic [LAT-1:0]              vld_q;
	logic                        en;

	logic signed [DW-1:0]               diff_s1 [NC];
	logic signed [rosi_pkg::DIR_W-1:0]  dir_s1  [NC];
	logic [rosi_pkg::HALF_W-1:0]        half_s1 [NS];
	rosi_pkg::rosi_slab_t               slab_c  [NS];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q[0] <= rosi_pkg::AXIS_ONE_RST;
			axis_q[1] <= rosi_pkg::AXIS_TWO_RST;
			axis_q[2] <= rosi_pkg::AXIS_THREE_RST;
			thr_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				rosi_pkg::REG_AXIS_ONE:   axis_q[0] <= cfg_data;
				rosi_pkg::REG_AXIS_TWO:   axis_q[1] <= cfg_data;
				rosi_pkg::REG_AXIS_THREE: axis_q[2] <= cfg_data;
				rosi_pkg::REG_THRESHOLD:  thr_q     <= cfg_data[rosi_pkg::THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// whole pipeline advances unless the last result is held
	assign en           = !vld_q[LAT-1] || res_out.ready;
	assign ray_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], ray_in.valid};
		end
	end

	// input stage: center minus origin, direction and half sizes registered
	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1[0] <= DW'(ray_in.center_x) - DW'(ray_in.origin_x);
			diff_s1[1] <= DW'(ray_in.center_y) - DW'(ray_in.origin_y);
			diff_s1[2] <= DW'(ray_in.center_z) - DW'(ray_in.origin_z);
			dir_s1[0]  <= ray_in.dir_x;
			dir_s1[1]  <= ray_in.dir_y;
			dir_s1[2]  <= ray_in.dir_z;
			half_s1[0] <= ray_in.half_one;
			half_s1[1] <= ray_in.half_two;
			half_s1[2] <= ray_in.half_three;
		end
	end

	// one lane per box axis
	for (genvar i = 0; i < NS; i++) begin : g_lane
		rosi_lane u_lane (
			.clk  (clk),
			.en   (en),
			.axis (axis_q[i]),
			.thr  (thr_q),
			.diff (diff_s1),
			.dir  (dir_s1),
			.half (half_s1[i]),
			.slab (slab_c[i])
		);
	end

	rosi_merge u_merge (
		.clk      (clk),
		.en       (en),
		.slab     (slab_c),
		.hit      (res_out.hit),
		.distance (res_out.hit_distance)
	);

	assign res_out.valid = vld_q[LAT-1];

	// checks
	`ROSI_ASSERT_NOW(a_miss_zero, res_out.valid && !res_out.hit, res_out.hit_distance == '0, "miss item with nonzero distance")
	`ROSI_ASSERT_NOW(a_hit_ahead, res_out.valid && res_out.hit, !res_out.hit_distance[rosi_pkg::COORD_W-1], "hit item with negative distance")
	`ROSI_ASSERT_NEXT(a_take, ray_in.valid && ray_in.ready, vld_q[0], "accepted item missing from first stage")
	`ROSI_ASSERT_NEXT(a_hold, !en, $stable(vld_q), "pipeline moved while stalled")

endmodule
